>>> sv/lru_key_value_cache_unit_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LKVC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc assertion failed");
// Next-cycle implication.
`define LKVC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_IMP(name, clk, rst, ante, cons)
`define LKVC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

>>> sv/lkvc_pkg.sv
package lkvc_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_WIDTH   = 64;
   localparam int VALUE_WIDTH = 64;

   localparam int FIELD_W  = 64;
   localparam int OPCODE_W = 2;
   localparam int CAP_W    = 5;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int OCC_W    = $clog2(ENTRIES + 1);
   localparam int CMP_W    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_CAPACITY  = REG_IDX_W'(0);
   localparam logic [CAP_W-1:0]     CAPACITY_RESET = CAP_W'(16);

   localparam logic [OPCODE_W-1:0] OPC_GET  = OPCODE_W'(0);
   localparam logic [OPCODE_W-1:0] OPC_SET  = OPCODE_W'(1);
   localparam logic [OPCODE_W-1:0] OPC_LIST = OPCODE_W'(2);

   typedef enum logic [1:0] {
      KIND_GET,
      KIND_SET,
      KIND_LIST,
      KIND_NOP
   } lkvc_kind_type;

   typedef enum logic [1:0] {
      ENG_LOOK,
      ENG_EXEC,
      ENG_LIST
   } lkvc_eng_state_type;

   typedef struct packed {
      lkvc_kind_type          kind;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } lkvc_item_type;

   typedef struct packed {
      logic          valid;
      lkvc_item_type item;
   } lkvc_head_type;

   typedef struct packed {
      logic [ENTRIES-1:0] valid;
      logic [OCC_W-1:0]   occupancy;
      logic               listing;
   } lkvc_eng_status_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [IDX_W-1:0] first_index(input logic [ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> sv/lkvc_front.sv
module lkvc_front import lkvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [FIELD_W-1:0]  req_key,
   input  logic [FIELD_W-1:0]  req_value,
   output lkvc_head_type       head,
   input  logic                pop
);

   lkvc_item_type       q_mem [QUEUE_DEPTH];
   lkvc_item_type       new_item;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   always_comb begin
      case (req_opcode)
         OPC_GET:  new_item.kind = KIND_GET;
         OPC_SET:  new_item.kind = KIND_SET;
         OPC_LIST: new_item.kind = KIND_LIST;
         default:  new_item.kind = KIND_NOP;
      endcase
      new_item.key   = req_key[KEY_WIDTH-1:0];
      new_item.value = req_value[VALUE_WIDTH-1:0];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_mem[rd_ptr_ff];

endmodule

>>> sv/lkvc_engine.sv
module lkvc_engine import lkvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lkvc_head_type       head,
   output logic                pop,
   input  logic [CAP_W-1:0]    capacity,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [FIELD_W-1:0]  rsp_data,
   output logic [FIELD_W-1:0]  rsp_key_out,
   output logic                rsp_last,
   output lkvc_eng_status_type status
);

   lkvc_eng_state_type     state_ff, state_in;
   lkvc_kind_type          kind_ff, kind_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [ENTRIES-1:0]     match_ff, match_in;
   logic [IDX_W-1:0]       list_rank_ff, list_rank_in;

   logic [KEY_WIDTH-1:0]   key_store   [ENTRIES];
   logic [VALUE_WIDTH-1:0] value_store [ENTRIES];
   logic [IDX_W-1:0]       rank_ff [ENTRIES];
   logic [IDX_W-1:0]       rank_in [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [FIELD_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [FIELD_W-1:0]     rsp_key_ff, rsp_key_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   hit;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       hit_rank;
   logic [CMP_W-1:0]       cap_ext;
   logic [CMP_W-1:0]       eff_cap;
   logic                   evict;
   logic [ENTRIES-1:0]     victim;
   logic [ENTRIES-1:0]     valid_kept;
   logic [IDX_W-1:0]       ins_idx;
   logic                   ins_ok;
   logic [ENTRIES-1:0]     list_sel;
   logic [IDX_W-1:0]       list_idx;
   logic                   list_last;

   logic                   st_we;
   logic                   st_key_we;
   logic [IDX_W-1:0]       st_idx;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = |match_ff;
   assign hit_idx  = first_index(match_ff);
   assign hit_rank = rank_ff[hit_idx];

   // Zero capacity acts as one entry, anything above the array size as full size.
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (capacity == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // Valid ranks always form 0 .. occupancy-1, so the victim holds the top rank.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i]   = valid_ff[i] && (rank_ff[i] == IDX_W'(occ_ff - 1'b1));
         list_sel[i] = valid_ff[i] && (rank_ff[i] == list_rank_ff);
      end
   end

   assign evict      = (CMP_W'(occ_ff) >= eff_cap) && (occ_ff != '0);
   assign valid_kept = valid_ff & ~(evict ? victim : '0);
   assign ins_idx    = first_index(~valid_kept);
   assign ins_ok     = |(~valid_kept);
   assign list_idx   = first_index(list_sel);
   assign list_last  = ((OCC_W'(list_rank_ff) + OCC_W'(1)) == occ_ff);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      match_in     = match_ff;
      list_rank_in = list_rank_ff;
      rank_in      = rank_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      st_we        = 1'b0;
      st_key_we    = 1'b0;
      st_idx       = hit_idx;

      case (state_ff)
         ENG_LOOK: begin
            if (head.valid) begin
               pop      = 1'b1;
               kind_in  = head.item.kind;
               key_in   = head.item.key;
               value_in = head.item.value;
               for (int i = 0; i < ENTRIES; i++) begin
                  match_in[i] = valid_ff[i] && (key_store[i] == head.item.key);
               end
               state_in = ENG_EXEC;
            end
         end
         ENG_EXEC: begin
            if (out_free) begin
               state_in    = ENG_LOOK;
               rsp_hit_in  = 1'b0;
               rsp_data_in = '0;
               rsp_key_in  = '0;
               rsp_last_in = 1'b1;
               case (kind_ff)
                  KIND_GET: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                           if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                              rank_in[i] = rank_ff[i] + 1'b1;
                           end
                        end
                        rank_in[hit_idx] = '0;
                        rsp_hit_in       = 1'b1;
                        rsp_data_in      = FIELD_W'(value_store[hit_idx]);
                     end
                  end
                  KIND_SET: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                           if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                              rank_in[i] = rank_ff[i] + 1'b1;
                           end
                        end
                        rank_in[hit_idx] = '0;
                        st_we            = 1'b1;
                        rsp_hit_in       = 1'b1;
                     end else begin
                        for (int i = 0; i < ENTRIES; i++) begin
                           if (evict && victim[i]) begin
                              rank_in[i] = '0;
                           end
                           if (ins_ok && valid_kept[i]) begin
                              rank_in[i] = rank_ff[i] + 1'b1;
                           end
                        end
                        valid_in = valid_kept;
                        occ_in   = occ_ff - OCC_W'(evict);
                        if (ins_ok) begin
                           rank_in[ins_idx]  = '0;
                           valid_in[ins_idx] = 1'b1;
                           occ_in            = occ_ff - OCC_W'(evict) + OCC_W'(1);
                           st_we             = 1'b1;
                           st_key_we         = 1'b1;
                           st_idx            = ins_idx;
                        end
                     end
                  end
                  KIND_LIST: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        list_rank_in = '0;
                        state_in     = ENG_LIST;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ENG_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_data_in  = '0;
               rsp_key_in   = FIELD_W'(key_store[list_idx]);
               rsp_last_in  = list_last;
               if (list_last) begin
                  state_in = ENG_LOOK;
               end else begin
                  list_rank_in = list_rank_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ENG_LOOK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_LOOK;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         list_rank_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         list_rank_ff <= list_rank_in;
         rank_ff      <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      match_ff    <= match_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         value_store[st_idx] <= value_ff;
      end
      if (st_key_we) begin
         key_store[st_idx] <= key_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_last    = rsp_last_ff;

   assign status.valid     = valid_ff;
   assign status.occupancy = occ_ff;
   assign status.listing   = (state_ff == ENG_LIST);

endmodule

>>> sv/lru_key_value_cache_unit.sv
// An accepted get, set or unknown item is queued; the engine compares its key in the look state,
// then updates ranks and store and registers its result in the exec state, one item at a time.
// A list item gives one result per held entry, in rank order, the last with rsp_last; an empty list gives one.
// Reset (synchronous) empties the cache at once and sets capacity to 16; no clearing pass.
`include "lru_key_value_cache_unit_defines.svh"

module lru_key_value_cache_unit import lkvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [FIELD_W-1:0]    req_key,
   input  logic [FIELD_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [FIELD_W-1:0]    rsp_data,
   output logic [FIELD_W-1:0]    rsp_key_out,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   lkvc_head_type       head;
   logic                pop;
   lkvc_eng_status_type eng_status;
   logic [CAP_W-1:0]    capacity_ff, capacity_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (reg_idx == REG_CAPACITY)) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
      if (reg_idx == REG_CAPACITY) begin
         csr_prdata = CSR_DATA_W'(capacity_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lkvc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_key    (req_key),
      .req_value  (req_value),
      .head       (head),
      .pop        (pop)
   );

   lkvc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .capacity    (capacity_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_hit     (rsp_hit),
      .rsp_data    (rsp_data),
      .rsp_key_out (rsp_key_out),
      .rsp_last    (rsp_last),
      .status      (eng_status)
   );

   // The fill count must always agree with the valid bits.
   `LKVC_ASSERT_IMP(a_occ_matches_valid, clock, reset, 1'b1, $countones(eng_status.valid) == eng_status.occupancy)
   // A result that is not the last one can only come from a list still in progress.
   `LKVC_ASSERT_IMP(a_partial_list, clock, reset, rsp_valid && !rsp_last, eng_status.listing)
   // One item changes the fill count by at most one entry.
   `LKVC_ASSERT_NXT(a_occ_step, clock, reset, 1'b1, (eng_status.occupancy == $past(eng_status.occupancy)) || (eng_status.occupancy == $past(eng_status.occupancy) + 1'b1) || (eng_status.occupancy == $past(eng_status.occupancy) - 1'b1))

endmodule
